### hdl/assert_macros.svh
// assertion macros used by the normalizer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define SMCN_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SMCN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/smcn_pkg.sv
// types and constants shared by the normalizer rtl
`timescale 1ns / 1ps

package smcn_pkg;

    // bound and divider widths
    localparam int BOUND_W   = 12;
    localparam int DIV_NUM_W = 19;
    localparam int DIV_DEN_W = 12;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // word field widths
    localparam int OP_W     = 3;
    localparam int CHAN_W   = 3;
    localparam int KIND_W   = 2;
    localparam int MAPPED_W = 19;
    localparam int ADDR_W   = 4;
    localparam int VALUE_W  = 8;
    localparam int HYST_W   = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    // arithmetic constants
    localparam logic [BOUND_W-1:0]   START_MIN     = 12'd1200;
    localparam logic [DIV_NUM_W-1:0] MAP_SCALE     = 19'd100;
    localparam logic [DIV_DEN_W-1:0] STORE_DIVISOR = 12'd10;
    localparam logic [DIV_NUM_W-1:0] MAP_LIMIT     = 19'd255000;
    localparam logic [HYST_W-1:0]    HYST_RESET    = 8'd10;

    // bound / 10 as (bound * 52429) >> 19, exact for any 12 bit bound
    localparam int                 DIV10_W     = 16;
    localparam logic [DIV10_W-1:0] DIV10_MULT  = 16'd52429;
    localparam int                 DIV10_SHIFT = 19;

    typedef enum logic [OP_W-1:0] {
        OP_MEASURE = 3'd0,
        OP_START   = 3'd1,
        OP_CALIB   = 3'd2,
        OP_COMMIT  = 3'd3,
        OP_LOAD    = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_MAPPED = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

### hdl/smcn_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module smcn_div
    import smcn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W+1:0] w_sub;
    logic                 w_ge;

    assign w_rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_sub    = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_ge     = !w_sub[DIV_DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_quo  <= i_req.num;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

### hdl/sensor_minmax_calibrate_normalize_core.sv
// Reflectance normalizer for CHANNELS sensor channels. Each input word carries an operation
// in s_axis_tuser: measure maps a sample to (sample - min) * 100 / (max - min), truncated
// toward zero and saturated to +/-255000, with zero_span set and the value forced to 0 when
// max equals min; calibrate sample maps the same way with the old bounds and then widens the
// channel's min and max; start sets every min to 1200 and every max to 0; load writes one
// channel's bounds; commit walks the channels, min bound then max bound, and for each bound
// that differs from its stored copy by more than store_hysteresis emits a store record
// (address, low byte of bound / 10) and takes the bound as the new copy, then ends with a done word.
// Start, load, unknown operations and out-of-range channels give no output word.
// The mapping division runs on one shared restoring divider that makes one quotient bit per
// cycle, so a measure or calibrate word holds the input closed through setup, division and
// output (the division is skipped when the span is zero); start and load leave the sequencer idle.
// The bound / 10 of a store record comes from a reciprocal multiply. A commit checks each
// bound in turn, adds an output step for each stored bound and ends with a done word step;
// output stalls hold the walk in its output steps. One output register holds a finished
// word, so the next input word is taken while the last result still waits downstream.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sensor_minmax_calibrate_normalize_core
    import smcn_pkg::*;
#(
    parameter int CHANNELS    = 6,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: store_hysteresis
    input  logic                        i_cfg_wr_en,
    input  logic [HYST_W-1:0]           i_cfg_wr_data,
    // input words
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // channel, sample, load_min, load_max (from bit 0 up), zero padded to bytes
    input  logic [((CHAN_W + SAMPLE_BITS + 2*BOUND_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]             s_axis_tuser,
    // output words
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // mapped, store_address, store_value (from bit 0 up), zero padded
    output logic [M_TDATA_W-1:0]        m_axis_tdata,
    // kind, zero_span (from bit 0 up)
    output logic [M_TUSER_W-1:0]        m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SMP_LSB = CHAN_W;
    localparam int MIN_LSB = CHAN_W + SAMPLE_BITS;
    localparam int MAX_LSB = CHAN_W + SAMPLE_BITS + BOUND_W;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_SETUP,
        S_MAP_DIV,
        S_MAP_OUT,
        S_CMT_CHECK,
        S_CMT_OUT,
        S_DONE_OUT
    } t_state;

    // calibration state
    logic [BOUND_W-1:0] r_bound_min  [CHANNELS];
    logic [BOUND_W-1:0] r_bound_max  [CHANNELS];
    logic [BOUND_W-1:0] r_stored_min [CHANNELS];
    logic [BOUND_W-1:0] r_stored_max [CHANNELS];
    logic [HYST_W-1:0]  r_hyst;

    // sequencer
    t_state                 r_state;
    t_op                    r_op;
    logic [CH_W-1:0]        r_idx;
    logic                   r_is_max;
    logic [SAMPLE_BITS-1:0] r_x;
    logic                   r_neg;
    logic                   r_zero;

    // shared divider request
    logic                 r_div_start;
    logic [DIV_NUM_W-1:0] r_div_num;
    logic [DIV_DEN_W-1:0] r_div_den;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    // output register
    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [MAPPED_W-1:0] r_out_mapped;
    logic                r_out_zero;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_last;

    // input word fields
    logic [CHAN_W-1:0]      w_in_ch;
    logic [SAMPLE_BITS-1:0] w_in_x;
    logic [BOUND_W-1:0]     w_in_min;
    logic [BOUND_W-1:0]     w_in_max;
    logic                   w_in_ch_ok;
    logic                   w_accept;

    // mapping datapath
    logic [BOUND_W-1:0]   w_x12;
    logic [BOUND_W-1:0]   w_lo;
    logic [BOUND_W-1:0]   w_hi;
    logic [BOUND_W:0]     w_diff;
    logic [BOUND_W:0]     w_span;
    logic [BOUND_W:0]     w_diff_abs;
    logic [BOUND_W:0]     w_span_abs;
    logic [DIV_NUM_W-1:0] w_num;
    logic [DIV_NUM_W-1:0] w_q_sat;
    logic [MAPPED_W-1:0]  w_mapped;

    // commit datapath
    logic [BOUND_W-1:0]         w_cb;
    logic [BOUND_W-1:0]         w_cs;
    logic [BOUND_W:0]           w_cd;
    logic [BOUND_W:0]           w_cd_abs;
    logic                       w_moved;
    logic                       w_walk_end;
    logic [CH_W:0]              w_addr_sum;
    logic [BOUND_W+DIV10_W-1:0] w_cb_prod;
    logic [VALUE_W-1:0]         w_cb_tenth;
    logic                       w_slot_free;

    assign w_in_ch    = s_axis_tdata[CHAN_W-1:0];
    assign w_in_x     = s_axis_tdata[SMP_LSB +: SAMPLE_BITS];
    assign w_in_min   = s_axis_tdata[MIN_LSB +: BOUND_W];
    assign w_in_max   = s_axis_tdata[MAX_LSB +: BOUND_W];
    assign w_in_ch_ok = (int'(w_in_ch) < CHANNELS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    // signed difference and span as magnitude plus sign
    assign w_x12      = BOUND_W'(r_x);
    assign w_lo       = r_bound_min[r_idx];
    assign w_hi       = r_bound_max[r_idx];
    assign w_diff     = {1'b0, w_x12} - {1'b0, w_lo};
    assign w_span     = {1'b0, w_hi} - {1'b0, w_lo};
    assign w_diff_abs = w_diff[BOUND_W] ? ((BOUND_W+1)'(0) - w_diff) : w_diff;
    assign w_span_abs = w_span[BOUND_W] ? ((BOUND_W+1)'(0) - w_span) : w_span;
    assign w_num      = DIV_NUM_W'(w_diff_abs[BOUND_W-1:0]) * MAP_SCALE;

    // saturate the quotient magnitude, then apply the sign
    assign w_q_sat  = (w_div_rsp.quot > MAP_LIMIT) ? MAP_LIMIT : w_div_rsp.quot;
    assign w_mapped = r_neg ? (MAPPED_W'(0) - MAPPED_W'(w_q_sat)) : MAPPED_W'(w_q_sat);

    // hysteresis test for the bound under the walk pointer
    assign w_cb       = r_is_max ? r_bound_max[r_idx] : r_bound_min[r_idx];
    assign w_cs       = r_is_max ? r_stored_max[r_idx] : r_stored_min[r_idx];
    assign w_cd       = {1'b0, w_cb} - {1'b0, w_cs};
    assign w_cd_abs   = w_cd[BOUND_W] ? ((BOUND_W+1)'(0) - w_cd) : w_cd;
    assign w_moved    = (w_cd_abs > (BOUND_W+1)'(r_hyst));
    assign w_walk_end = r_is_max && (r_idx == LAST_IDX);
    assign w_addr_sum = r_is_max ? ((CH_W+1)'(r_idx) + (CH_W+1)'(CHANNELS))
                                 : (CH_W+1)'(r_idx);

    // bound / 10 by reciprocal multiply, low byte kept
    assign w_cb_prod  = (BOUND_W+DIV10_W)'(w_cb) * (BOUND_W+DIV10_W)'(DIV10_MULT);
    assign w_cb_tenth = w_cb_prod[DIV10_SHIFT +: VALUE_W];

    assign w_div_req.start = r_div_start;
    assign w_div_req.num   = r_div_num;
    assign w_div_req.den   = r_div_den;

    smcn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_MEASURE;
            r_idx       <= '0;
            r_is_max    <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_hyst      <= HYST_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                r_bound_min[i]  <= '0;
                r_bound_max[i]  <= '0;
                r_stored_min[i] <= '0;
                r_stored_max[i] <= '0;
            end
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_wr_en) begin
                r_hyst <= i_cfg_wr_data;
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= t_op'(s_axis_tuser);
                        r_idx <= CH_W'(w_in_ch);
                        r_x   <= w_in_x;
                        case (t_op'(s_axis_tuser))
                            OP_MEASURE, OP_CALIB: begin
                                if (w_in_ch_ok) begin
                                    r_state <= S_MAP_SETUP;
                                end
                            end
                            OP_START: begin
                                for (int i = 0; i < CHANNELS; i++) begin
                                    r_bound_min[i] <= START_MIN;
                                    r_bound_max[i] <= '0;
                                end
                            end
                            OP_COMMIT: begin
                                r_idx    <= '0;
                                r_is_max <= 1'b0;
                                r_state  <= S_CMT_CHECK;
                            end
                            OP_LOAD: begin
                                if (w_in_ch_ok) begin
                                    r_bound_min[CH_W'(w_in_ch)] <= w_in_min;
                                    r_bound_max[CH_W'(w_in_ch)] <= w_in_max;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_MAP_SETUP: begin
                    // old bounds feed the division, calibrate widens them afterwards
                    r_neg     <= w_diff[BOUND_W] ^ w_span[BOUND_W];
                    r_zero    <= (w_span == '0);
                    r_div_num <= w_num;
                    r_div_den <= w_span_abs[BOUND_W-1:0];
                    if (w_span == '0) begin
                        r_state <= S_MAP_OUT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_MAP_DIV;
                    end
                    if (r_op == OP_CALIB) begin
                        if (w_x12 < w_lo) begin
                            r_bound_min[r_idx] <= w_x12;
                        end
                        if (w_x12 > w_hi) begin
                            r_bound_max[r_idx] <= w_x12;
                        end
                    end
                end

                S_MAP_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_MAP_OUT;
                    end
                end

                S_MAP_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_MAPPED;
                        r_out_mapped <= r_zero ? '0 : w_mapped;
                        r_out_zero   <= r_zero;
                        r_out_addr   <= '0;
                        r_out_value  <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                S_CMT_CHECK: begin
                    if (w_moved) begin
                        // the copy follows the bound now, the record goes out next
                        if (r_is_max) begin
                            r_stored_max[r_idx] <= w_cb;
                        end else begin
                            r_stored_min[r_idx] <= w_cb;
                        end
                        r_state <= S_CMT_OUT;
                    end else if (w_walk_end) begin
                        r_state <= S_DONE_OUT;
                    end else begin
                        if (r_is_max) begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_is_max <= !r_is_max;
                    end
                end

                S_CMT_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_RECORD;
                        r_out_mapped <= '0;
                        r_out_zero   <= 1'b0;
                        r_out_addr   <= ADDR_W'(w_addr_sum);
                        r_out_value  <= w_cb_tenth;
                        r_out_last   <= 1'b0;
                        if (w_walk_end) begin
                            r_state <= S_DONE_OUT;
                        end else begin
                            if (r_is_max) begin
                                r_idx <= r_idx + 1'b1;
                            end
                            r_is_max <= !r_is_max;
                            r_state  <= S_CMT_CHECK;
                        end
                    end
                end

                S_DONE_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_DONE;
                        r_out_mapped <= '0;
                        r_out_zero   <= 1'b0;
                        r_out_addr   <= '0;
                        r_out_value  <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - MAPPED_W - ADDR_W - VALUE_W)'(0),
                            r_out_value, r_out_addr, r_out_mapped};
    assign m_axis_tuser  = {r_out_zero, r_out_kind};
    assign m_axis_tlast  = r_out_last;

    // a done word always closes the item
    `SMCN_ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[KIND_W-1:0] == KIND_DONE), m_axis_tlast, "done word without tlast")

    // a zero span reading carries a zero value
    `SMCN_ASSERT_IMPLY(a_zero_span_value, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[KIND_W], m_axis_tdata[MAPPED_W-1:0] == '0, "zero span with nonzero mapped value")

    // the divider only finishes while the sequencer waits for it
    `SMCN_ASSERT_IMPLY(a_div_done_expected, i_clk, i_rst_n, w_div_rsp.done, r_state == S_MAP_DIV, "divider result with no waiting step")

    // a started division leaves the sequencer waiting on the divider
    `SMCN_ASSERT_NEXT(a_div_start_wait, i_clk, i_rst_n, r_div_start, r_state == S_MAP_DIV, "divider started outside a wait step")

endmodule
